@@ design/nns_pkg.sv @@
// Shared types, constants and helpers for the nearest-neighbour pixel scaler.
package nns_pkg;

  // Default build-time limits
  localparam int unsigned SrcMaxDef     = 2048;
  localparam int unsigned DstMaxDef     = 4096;
  localparam int unsigned PixelBytesDef = 4;
  localparam int unsigned MaxFactorDef  = 8;

  // Configuration port
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [CfgIndexW-1:0] RegSourceWidth  = 3'd0;
  localparam logic [CfgIndexW-1:0] RegSourceHeight = 3'd1;
  localparam logic [CfgIndexW-1:0] RegTargetWidth  = 3'd2;
  localparam logic [CfgIndexW-1:0] RegTargetHeight = 3'd3;
  localparam logic [CfgIndexW-1:0] RegTargetPitch  = 3'd4;
  localparam logic [CfgIndexW-1:0] RegTargetBase   = 3'd5;

  // Register reset values
  localparam logic [11:0] SourceWidthRst  = 12'd320;
  localparam logic [11:0] SourceHeightRst = 12'd200;
  localparam logic [12:0] TargetWidthRst  = 13'd640;
  localparam logic [12:0] TargetHeightRst = 13'd480;
  localparam logic [15:0] TargetPitchRst  = 16'd2560;
  localparam logic [31:0] TargetBaseRst   = 32'd0;

  // Controller to datapath
  typedef struct packed {
    logic load;       // latch the incoming word
    logic start_div;  // compute the step factors
    logic calc;       // size the block and advance the scan
    logic addr;       // form the first row address
    logic emit;       // move one write into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic factors_ok;
    logic blk_empty;
    logic out_free;
    logic blk_last;
  } status_t;

  // Zero reads as one, oversize reads as the limit
  function automatic logic [31:0] clamp_size(input logic [31:0] v, input logic [31:0] lim);
    logic [31:0] r;
    if (v == 32'd0) begin
      r = 32'd1;
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ design/nns_div.sv @@
// Restoring divider, one quotient bit per cycle.
module nns_div import nns_pkg::*; #(
  parameter int unsigned N_W = 13,
  parameter int unsigned D_W = 12
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] num_i,
  input  logic [D_W-1:0] den_i,
  output logic           done_o,
  output logic [N_W-1:0] quo_o,
  output logic [D_W-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(N_W + 1);

  logic           busy_q;
  logic           done_q;
  logic [CntW-1:0] cnt_q;
  logic [N_W-1:0] quo_q;
  logic [D_W-1:0] rem_q;
  logic [D_W:0]   trial;
  logic           ge;

  assign trial = {rem_q, quo_q[N_W-1]};
  assign ge    = trial >= {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(N_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[N_W-2:0], ge};
      rem_q <= ge ? D_W'(trial - {1'b0, den_i}) : trial[D_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

@@ design/nns_datapath.sv @@
// Datapath: registers, scan accumulators, block counters and output word.
module nns_datapath import nns_pkg::*; #(
  parameter int unsigned SRC_MAX     = SrcMaxDef,
  parameter int unsigned DST_MAX     = DstMaxDef,
  parameter int unsigned PIXEL_BYTES = PixelBytesDef,
  parameter int unsigned MAX_FACTOR  = MaxFactorDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic [31:0]          pixel_in_i,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [31:0]          pixel_out_o,
  output logic [11:0]          dest_column_o,
  output logic [11:0]          dest_row_o,
  output logic [31:0]          dest_address_o,
  output logic                 run_last_o
);

  localparam int unsigned SW_W = $clog2(SRC_MAX + 1);
  localparam int unsigned DW_W = $clog2(DST_MAX + 1);
  localparam int unsigned FW   = $clog2(MAX_FACTOR + 1);
  localparam int unsigned PW   = DW_W + 16;

  // Configuration registers
  logic [11:0] src_w_q, src_h_q;
  logic [12:0] dst_w_q, dst_h_q;
  logic [15:0] pitch_q;
  logic [31:0] base_q;

  logic [SW_W-1:0] sw, sh;
  logic [DW_W-1:0] dw, dh;

  assign sw = SW_W'(clamp_size(32'(src_w_q), 32'(SRC_MAX)));
  assign sh = SW_W'(clamp_size(32'(src_h_q), 32'(SRC_MAX)));
  assign dw = DW_W'(clamp_size(32'(dst_w_q), 32'(DST_MAX)));
  assign dh = DW_W'(clamp_size(32'(dst_h_q), 32'(DST_MAX)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SourceWidthRst;
      src_h_q <= SourceHeightRst;
      dst_w_q <= TargetWidthRst;
      dst_h_q <= TargetHeightRst;
      pitch_q <= TargetPitchRst;
      base_q  <= TargetBaseRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegSourceWidth:  src_w_q <= cfg_data_i[11:0];
        RegSourceHeight: src_h_q <= cfg_data_i[11:0];
        RegTargetWidth:  dst_w_q <= cfg_data_i[12:0];
        RegTargetHeight: dst_h_q <= cfg_data_i[12:0];
        RegTargetPitch:  pitch_q <= cfg_data_i[15:0];
        RegTargetBase:   base_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Step factors: destination span per source step = q + (0 or 1)
  logic            col_done, row_done;
  logic [DW_W-1:0] col_q_f, row_q_f;
  logic [SW_W-1:0] col_r_f, row_r_f;
  logic            factors_ok_q;

  nns_div #(.N_W(DW_W), .D_W(SW_W)) u_div_col (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start_div),
    .num_i   (dw),
    .den_i   (sw),
    .done_o  (col_done),
    .quo_o   (col_q_f),
    .rem_o   (col_r_f)
  );

  nns_div #(.N_W(DW_W), .D_W(SW_W)) u_div_row (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start_div),
    .num_i   (dh),
    .den_i   (sh),
    .done_o  (row_done),
    .quo_o   (row_q_f),
    .rem_o   (row_r_f)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factors_ok_q <= 1'b0;
    end else if (cfg_we_i) begin
      factors_ok_q <= 1'b0;
    end else if (col_done) begin
      factors_ok_q <= 1'b1;
    end
  end

  // Scan accumulators; rem holds start*s minus the threshold so far
  logic [SW_W-1:0] src_col_q, src_row_q;
  logic [DW_W-1:0] col_start_q, row_start_q;
  logic [SW_W-1:0] col_rem_q, row_rem_q;

  logic [DW_W-1:0] nc, nr;
  logic [SW_W-1:0] col_rem_nx, row_rem_nx;
  logic [SW_W-1:0] src_col_inc, src_row_inc;
  logic            col_wrap, row_wrap;

  always_comb begin
    if (col_rem_q >= col_r_f) begin
      nc         = col_q_f;
      col_rem_nx = col_rem_q - col_r_f;
    end else begin
      nc         = col_q_f + DW_W'(1);
      col_rem_nx = SW_W'({1'b0, col_rem_q} + {1'b0, sw} - {1'b0, col_r_f});
    end
    if (row_rem_q >= row_r_f) begin
      nr         = row_q_f;
      row_rem_nx = row_rem_q - row_r_f;
    end else begin
      nr         = row_q_f + DW_W'(1);
      row_rem_nx = SW_W'({1'b0, row_rem_q} + {1'b0, sh} - {1'b0, row_r_f});
    end
  end

  assign src_col_inc = src_col_q + SW_W'(1);
  assign src_row_inc = src_row_q + SW_W'(1);
  assign col_wrap    = src_col_inc >= sw;
  assign row_wrap    = src_row_inc >= sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q   <= '0;
      src_row_q   <= '0;
      col_start_q <= '0;
      row_start_q <= '0;
      col_rem_q   <= '0;
      row_rem_q   <= '0;
    end else if (cfg_we_i) begin
      src_col_q   <= '0;
      src_row_q   <= '0;
      col_start_q <= '0;
      row_start_q <= '0;
      col_rem_q   <= '0;
      row_rem_q   <= '0;
    end else if (cmd_i.calc) begin
      if (!col_wrap) begin
        src_col_q   <= src_col_inc;
        col_start_q <= col_start_q + nc;
        col_rem_q   <= col_rem_nx;
      end else begin
        src_col_q   <= '0;
        col_start_q <= '0;
        col_rem_q   <= '0;
        if (row_wrap) begin
          // end of window: restart at the first pixel
          src_row_q   <= '0;
          row_start_q <= '0;
          row_rem_q   <= '0;
        end else begin
          src_row_q   <= src_row_inc;
          row_start_q <= row_start_q + nr;
          row_rem_q   <= row_rem_nx;
        end
      end
    end
  end

  // Block geometry, clipped to the largest block emitted
  logic [FW-1:0] ec, er;
  assign ec = (nc > DW_W'(MAX_FACTOR)) ? FW'(MAX_FACTOR) : FW'(nc);
  assign er = (nr > DW_W'(MAX_FACTOR)) ? FW'(MAX_FACTOR) : FW'(nr);

  logic [31:0]     pix_q;
  logic [DW_W-1:0] blk_col0_q, cur_col_q, cur_row_q;
  logic [FW-1:0]   ec_q, er_q, c_cnt_q, r_cnt_q;
  logic [PW-1:0]   prod_q;
  logic [31:0]     row_addr_q, col0_off_q, col_off_q;
  logic            c_end, r_end;

  assign c_end = c_cnt_q == (ec_q - FW'(1));
  assign r_end = r_cnt_q == (er_q - FW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pix_q <= pixel_in_i;
    end
    if (cmd_i.calc) begin
      blk_col0_q <= col_start_q;
      cur_col_q  <= col_start_q;
      cur_row_q  <= row_start_q;
      ec_q       <= ec;
      er_q       <= er;
      c_cnt_q    <= '0;
      r_cnt_q    <= '0;
      prod_q     <= PW'(row_start_q) * PW'(pitch_q);
    end
    if (cmd_i.addr) begin
      row_addr_q <= base_q + 32'(prod_q);
      col0_off_q <= 32'(blk_col0_q) * 32'(PIXEL_BYTES);
      col_off_q  <= 32'(blk_col0_q) * 32'(PIXEL_BYTES);
    end
    if (cmd_i.emit) begin
      if (c_end) begin
        // wrap to the block's first column, step one row down
        c_cnt_q    <= '0;
        cur_col_q  <= blk_col0_q;
        col_off_q  <= col0_off_q;
        r_cnt_q    <= r_cnt_q + FW'(1);
        cur_row_q  <= cur_row_q + DW_W'(1);
        row_addr_q <= row_addr_q + 32'(pitch_q);
      end else begin
        c_cnt_q   <= c_cnt_q + FW'(1);
        cur_col_q <= cur_col_q + DW_W'(1);
        col_off_q <= col_off_q + 32'(PIXEL_BYTES);
      end
    end
  end

  // Output register
  logic        out_valid_q;
  logic [31:0] out_pix_q, out_addr_q;
  logic [11:0] out_col_q, out_row_q;
  logic        out_last_q;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_pix_q  <= pix_q;
      out_col_q  <= 12'(cur_col_q);
      out_row_q  <= 12'(cur_row_q);
      out_addr_q <= row_addr_q + col_off_q;
      out_last_q <= c_end && r_end;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_out_o    = out_pix_q;
  assign dest_column_o  = out_col_q;
  assign dest_row_o     = out_row_q;
  assign dest_address_o = out_addr_q;
  assign run_last_o     = out_last_q;

  assign status_o.div_done   = col_done && row_done;
  assign status_o.factors_ok = factors_ok_q;
  assign status_o.blk_empty  = (nc == '0) || (nr == '0);
  assign status_o.out_free   = out_free;
  assign status_o.blk_last   = c_end && r_end;

  a_col_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_rem_q < sw)
    else $error("column remainder out of range");

  a_row_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_rem_q < sh)
    else $error("row remainder out of range");

  a_blk_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (c_cnt_q < ec_q) && (r_cnt_q < er_q))
    else $error("block counter beyond block size");

endmodule

@@ design/nns_ctrl.sv @@
// Controller: sequences factor setup, block sizing, addressing and writes.
module nns_ctrl import nns_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv  = 3'd1;
  localparam logic [2:0] StCalc = 3'd2;
  localparam logic [2:0] StAddr = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = state_q != StIdle;
  assign accept     = in_valid_i && (state_q == StIdle);

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.load      = accept;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (status_i.factors_ok) begin
            state_d = StCalc;
          end else begin
            cmd_o.start_div = 1'b1;
            state_d         = StDiv;
          end
        end
      end
      StDiv: begin
        if (status_i.div_done) begin
          state_d = StCalc;
        end
      end
      StCalc: begin
        cmd_o.calc = 1'b1;
        // a pixel that covers nothing still advances the scan
        state_d = status_i.blk_empty ? StIdle : StAddr;
      end
      StAddr: begin
        cmd_o.addr = 1'b1;
        state_d    = StEmit;
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.blk_last) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) && !status_i.out_free |=> state_q == StEmit)
    else $error("left emission while output was blocked");

  a_div_before_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> !status_i.factors_ok)
    else $error("factor computation running with factors already valid");

endmodule

@@ design/nearest_neighbor_pixel_scaler.sv @@
// Nearest-neighbour pixel scaler: top level joining controller and datapath.
//
// Source pixels enter one word at a time in raster order; each is written out
// over the destination block it covers, row by row, left to right, with the
// column, row and byte address of every write and a mark on the block's last
// write. No new pixel is taken until the current one is done: after accept the
// block is sized, the first row address is formed, and then one write per cycle
// moves into the output register while the output is not stalled; a pixel that
// covers nothing returns to idle straight after sizing. After reset or any
// register write the first pixel also waits for the per-step factors, worked out
// by a one-bit-per-cycle divider. Blocks are clipped to MAX_FACTOR columns and
// rows. Any register write restarts the scan at the window's first pixel.
module nearest_neighbor_pixel_scaler import nns_pkg::*; #(
  parameter int unsigned SRC_MAX     = SrcMaxDef,
  parameter int unsigned DST_MAX     = DstMaxDef,
  parameter int unsigned PIXEL_BYTES = PixelBytesDef,
  parameter int unsigned MAX_FACTOR  = MaxFactorDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [31:0]          pixel_in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [31:0]          pixel_out_o,
  output logic [11:0]          dest_column_o,
  output logic [11:0]          dest_row_o,
  output logic [31:0]          dest_address_o,
  output logic                 run_last_o
);

  cmd_t    cmd;
  status_t status;

  nns_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  nns_datapath #(
    .SRC_MAX     (SRC_MAX),
    .DST_MAX     (DST_MAX),
    .PIXEL_BYTES (PIXEL_BYTES),
    .MAX_FACTOR  (MAX_FACTOR)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pixel_in_i     (pixel_in_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .pixel_out_o    (pixel_out_o),
    .dest_column_o  (dest_column_o),
    .dest_row_o     (dest_row_o),
    .dest_address_o (dest_address_o),
    .run_last_o     (run_last_o)
  );

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the nearest-neighbour pixel scaler.
`timescale 1ns / 1ps

module testbench;
  import nns_pkg::*;

  localparam int unsigned Settle    = 24;
  localparam int unsigned NumRows   = 44;
  localparam int unsigned NumRandom = 197;

  // Indexes outside the register list: a write only restarts the scan
  localparam logic [CfgIndexW-1:0] RegSpare  = 3'd6;
  localparam logic [CfgIndexW-1:0] RegUnused = 3'd7;
  localparam logic [CfgIndexW-1:0] NoIndex   = 3'd0;

  typedef struct packed {
    logic [31:0] pixel;
    logic [11:0] column;
    logic [11:0] row;
    logic [31:0] address;
    logic        last;
  } write_t;

  typedef enum logic [1:0] {
    ROW_REG,    // register write
    ROW_PIXEL,  // pixel checked against the predictor
    ROW_TYPED   // pixel with its single write (or none) typed in
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  index;
    logic [31:0] data;
    logic        one_write;
    logic [11:0] column;
    logic [11:0] row;
    logic [31:0] address;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  logic [31:0] pixel_in_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [31:0] pixel_out_o;
  logic [11:0] dest_column_o;
  logic [11:0] dest_row_o;
  logic [31:0] dest_address_o;
  logic run_last_o;

  always #2 clk_i = ~clk_i;

  nearest_neighbor_pixel_scaler #(
    .SRC_MAX(SrcMaxDef),
    .DST_MAX(DstMaxDef),
    .PIXEL_BYTES(PixelBytesDef),
    .MAX_FACTOR(MaxFactorDef)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .pixel_in_i(pixel_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .pixel_out_o(pixel_out_o),
    .dest_column_o(dest_column_o),
    .dest_row_o(dest_row_o),
    .dest_address_o(dest_address_o),
    .run_last_o(run_last_o)
  );

  // Register mirror and scan state of the predictor
  logic [11:0] src_w_reg, src_h_reg;
  logic [12:0] dst_w_reg, dst_h_reg;
  logic [15:0] pitch_reg;
  logic [31:0] base_reg;
  int unsigned scan_x, scan_y, blk_x, blk_y, next_blk_y, x_limit, y_limit;

  write_t block_writes[$];
  write_t expected_writes[$];
  int unsigned mismatch_count = 0;
  bit steady = 1'b0;

  // Directed rows: extremes, masking of wide writes, wrap of the address,
  // out-of-list index, downscale gaps, zero and oversize sizes, clipping
  stim_row_t stim_rows [NumRows] = '{
    '{ROW_PIXEL, NoIndex, 32'h0000_0000, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_PIXEL, NoIndex, 32'hFFFF_FFFF, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_REG, RegSourceWidth, 32'hFFFF_F004, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_REG, RegSourceHeight, 32'd3, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_REG, RegTargetWidth, 32'd4, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_REG, RegTargetHeight, 32'd3, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_REG, RegTargetPitch, 32'd16, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_REG, RegTargetBase, 32'hFFFF_FFF0, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_TYPED, NoIndex, 32'h5555_5555, 1'b1, 12'd0, 12'd0, 32'hFFFF_FFF0},
    '{ROW_TYPED, NoIndex, 32'hAAAA_AAAA, 1'b1, 12'd1, 12'd0, 32'hFFFF_FFF4},
    '{ROW_TYPED, NoIndex, 32'h0F0F_0F0F, 1'b1, 12'd2, 12'd0, 32'hFFFF_FFF8},
    '{ROW_TYPED, NoIndex, 32'hF0F0_F0F0, 1'b1, 12'd3, 12'd0, 32'hFFFF_FFFC},
    '{ROW_TYPED, NoIndex, 32'h1234_5678, 1'b1, 12'd0, 12'd1, 32'h0000_0000},
    '{ROW_REG, RegUnused, 32'h0, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_TYPED, NoIndex, 32'h89AB_CDEF, 1'b1, 12'd0, 12'd0, 32'hFFFF_FFF0},
    '{ROW_REG, RegTargetWidth, 32'd1, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_TYPED, NoIndex, 32'h0000_0001, 1'b1, 12'd0, 12'd0, 32'hFFFF_FFF0},
    '{ROW_TYPED, NoIndex, 32'h0000_0002, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_TYPED, NoIndex, 32'h0000_0004, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_TYPED, NoIndex, 32'h0000_0008, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_TYPED, NoIndex, 32'h0000_0010, 1'b1, 12'd0, 12'd1, 32'h0000_0000},
    '{ROW_REG, RegSourceWidth, 32'd0, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_REG, RegTargetWidth, 32'd0, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_REG, RegTargetPitch, 32'hFFFF, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_TYPED, NoIndex, 32'h8000_0000, 1'b1, 12'd0, 12'd0, 32'hFFFF_FFF0},
    '{ROW_TYPED, NoIndex, 32'h7FFF_FFFF, 1'b1, 12'd0, 12'd1, 32'h0000_FFEF},
    '{ROW_TYPED, NoIndex, 32'h0000_0020, 1'b1, 12'd0, 12'd2, 32'h0001_FFEE},
    '{ROW_TYPED, NoIndex, 32'h0000_0040, 1'b1, 12'd0, 12'd0, 32'hFFFF_FFF0},
    '{ROW_REG, RegSourceWidth, 32'hFFF, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_REG, RegTargetWidth, 32'h1FFF, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_REG, RegTargetPitch, 32'd1, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_REG, RegTargetBase, 32'h0, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_PIXEL, NoIndex, 32'h0000_0080, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_PIXEL, NoIndex, 32'h0000_0100, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_REG, RegSourceWidth, 32'd1, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_REG, RegSourceHeight, 32'd1, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_REG, RegTargetWidth, 32'h1000, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_REG, RegTargetHeight, 32'h1FFF, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_PIXEL, NoIndex, 32'hDEAD_BEEF, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_PIXEL, NoIndex, 32'h00FF_00FF, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_REG, RegSourceHeight, 32'hFFF, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_REG, RegTargetHeight, 32'd0, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_PIXEL, NoIndex, 32'hC3C3_C3C3, 1'b0, 12'd0, 12'd0, 32'h0},
    '{ROW_PIXEL, NoIndex, 32'h3C3C_3C3C, 1'b0, 12'd0, 12'd0, 32'h0}
  };

  function automatic int unsigned effective_size(input int unsigned v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // Destination positions p >= start with p * s < limit
  function automatic int unsigned covered(input int unsigned start, input int unsigned limit,
                                          input int unsigned s);
    int unsigned stop;
    stop = (limit + s - 1) / s;
    return (stop > start) ? stop - start : 0;
  endfunction

  function automatic void restart_scan();
    scan_x = 0;
    scan_y = 0;
    blk_x = 0;
    blk_y = 0;
    next_blk_y = 0;
    x_limit = effective_size(32'(dst_w_reg), DstMaxDef);
    y_limit = effective_size(32'(dst_h_reg), DstMaxDef);
  endfunction

  function automatic void apply_reg(input logic [CfgIndexW-1:0] idx, input logic [31:0] data);
    case (idx)
      RegSourceWidth: src_w_reg = data[11:0];
      RegSourceHeight: src_h_reg = data[11:0];
      RegTargetWidth: dst_w_reg = data[12:0];
      RegTargetHeight: dst_h_reg = data[12:0];
      RegTargetPitch: pitch_reg = data[15:0];
      RegTargetBase: base_reg = data;
      default: ;
    endcase
    restart_scan();
  endfunction

  // Work out the writes of one source pixel and advance the scan
  function automatic void predict_block(input logic [31:0] pix);
    int unsigned sw, sh, dw, dh, ncol, nrow, ecol, erow, total, n, r, c;
    logic [31:0] addr;
    write_t w;
    sw = effective_size(32'(src_w_reg), SrcMaxDef);
    sh = effective_size(32'(src_h_reg), SrcMaxDef);
    dw = effective_size(32'(dst_w_reg), DstMaxDef);
    dh = effective_size(32'(dst_h_reg), DstMaxDef);
    block_writes.delete();
    ncol = covered(blk_x, x_limit, sw);
    nrow = covered(blk_y, y_limit, sh);
    next_blk_y = blk_y + nrow;
    ecol = (ncol > MaxFactorDef) ? MaxFactorDef : ncol;
    erow = (nrow > MaxFactorDef) ? MaxFactorDef : nrow;
    total = ecol * erow;
    n = 0;
    for (r = 0; r < erow; r++) begin
      for (c = 0; c < ecol; c++) begin
        addr = base_reg + (blk_y + r) * 32'(pitch_reg) + (blk_x + c) * PixelBytesDef;
        n++;
        w.pixel = pix;
        w.column = 12'(blk_x + c);
        w.row = 12'(blk_y + r);
        w.address = addr;
        w.last = (n == total);
        block_writes.push_back(w);
      end
    end
    // Advance by the full coverage, not the clipped block
    blk_x += ncol;
    x_limit += dw;
    scan_x++;
    if (scan_x >= sw) begin
      scan_x = 0;
      blk_x = 0;
      x_limit = dw;
      blk_y = next_blk_y;
      y_limit += dh;
      scan_y++;
      if (scan_y >= sh) begin
        restart_scan();
      end
    end
  endfunction

  function automatic bit idle_now();
    return !steady && ($urandom_range(99) < 33);
  endfunction

  function automatic logic [31:0] pick_size(input logic [31:0] field_max,
                                            input int unsigned common_hi);
    int unsigned roll;
    roll = $urandom_range(7);
    if (roll == 0) return 32'd0;
    if (roll == 1) return field_max;
    return $urandom_range(common_hi, 1);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 40) begin
      $display("tb: %s mismatch at %0t: got %0h, want %0h", what, $realtime, got, want);
    end
    mismatch_count++;
  endtask

  // Hold the register write until the next edge; the next pixel lowers the enable
  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    apply_reg(idx, data);
  endtask

  task automatic send_pixel(input logic [31:0] pix, input bit typed, input bit one_write,
                            input write_t typed_write);
    cfg_we_i <= 1'b0;
    while (idle_now()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= pix;
    do @(posedge clk_i); while (in_stall_o);
    predict_block(pix);
    if (typed) begin
      if (one_write) expected_writes.push_back(typed_write);
    end else begin
      foreach (block_writes[i]) expected_writes.push_back(block_writes[i]);
    end
  endtask

  task automatic wait_drained(input int unsigned settle);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_writes.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  // Output side: check each accepted write, then pick the next stall
  initial begin
    write_t seen;
    write_t want;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        seen = '{pixel_out_o, dest_column_o, dest_row_o, dest_address_o, run_last_o};
        if (expected_writes.size() == 0) begin
          report_mismatch("spare write", seen.address, 32'h0);
        end else begin
          want = expected_writes.pop_front();
          if (seen.pixel !== want.pixel) report_mismatch("pixel", seen.pixel, want.pixel);
          if (seen.column !== want.column) begin
            report_mismatch("column", 32'(seen.column), 32'(want.column));
          end
          if (seen.row !== want.row) begin
            report_mismatch("row", 32'(seen.row), 32'(want.row));
          end
          if (seen.address !== want.address) begin
            report_mismatch("address", seen.address, want.address);
          end
          if (seen.last !== want.last) begin
            report_mismatch("last", 32'(seen.last), 32'(want.last));
          end
        end
      end
      out_stall_i <= idle_now();
    end
  end

  initial begin
    int unsigned random_items;
    int unsigned phase;
    int unsigned count;
    int unsigned k;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = NoIndex;
    cfg_data_i = 32'h0;
    in_valid_i = 1'b0;
    pixel_in_i = 32'h0;
    src_w_reg = SourceWidthRst;
    src_h_reg = SourceHeightRst;
    dst_w_reg = TargetWidthRst;
    dst_h_reg = TargetHeightRst;
    pitch_reg = TargetPitchRst;
    base_reg = TargetBaseRst;
    restart_scan();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      if (stim_rows[i].kind == ROW_REG) begin
        if (i == 0 || stim_rows[i - 1].kind != ROW_REG) wait_drained(Settle);
        write_reg(stim_rows[i].index, stim_rows[i].data);
      end else begin
        send_pixel(stim_rows[i].data, stim_rows[i].kind == ROW_TYPED, stim_rows[i].one_write,
                   write_t'{stim_rows[i].data, stim_rows[i].column, stim_rows[i].row,
                            stim_rows[i].address, 1'b1});
      end
    end

    // Random phases: fresh sizes, pitch and base each time, full random pixels
    random_items = 0;
    phase = 0;
    while (random_items < NumRandom) begin
      wait_drained(Settle);
      steady = 1'b0;
      write_reg(RegSourceWidth, ($urandom() << 12) | pick_size(32'hFFF, 6));
      write_reg(RegSourceHeight, ($urandom() << 12) | pick_size(32'hFFF, 5));
      write_reg(RegTargetWidth, ($urandom() << 13) | pick_size(32'h1FFF, 20));
      write_reg(RegTargetHeight, ($urandom() << 13) | pick_size(32'h1FFF, 20));
      write_reg(RegTargetPitch, $urandom());
      write_reg(RegTargetBase, $urandom());
      if ($urandom_range(2) == 0) begin
        write_reg($urandom_range(1) ? RegSpare : RegUnused, $urandom());
      end
      steady = (phase == 2);
      count = $urandom_range(40, 12);
      for (k = 0; k < count && random_items < NumRandom; k++) begin
        // Hold off mid-phase until every write has come out
        if (k == count / 2) wait_drained(0);
        send_pixel($urandom(), 1'b0, 1'b0, '0);
        random_items++;
      end
      phase++;
    end

    wait_drained(Settle);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
